// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons holds whenever ante holds.
`define C2E_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons holds in the cycle after ante.
`define C2E_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/c2e_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_pkg
// Types, constants and tables for the calendar to epoch seconds pipeline.
// ----------------------------------------------------------------------------
package c2e_pkg;

   // pipeline depth from accepted item to result strobe
   localparam int PipeDepth = 6;

   // month folding: bias keeps (month + bias) positive, bias = 11 * 12
   localparam logic [9:0]  MonthBias   = 10'd132;
   localparam logic [16:0] Recip12     = 17'd171;   // 2^11 / 12, rounded up
   localparam logic [14:0] MonthCarry  = 15'd11;

   // year counting: G = full year - 1 + 6400 stays positive for every
   // normalized year; 6400 is a whole number of 400-year cycles
   localparam logic [14:0] YearBias    = 15'd8299;
   localparam logic [24:0] Recip25     = 25'd5243;  // 2^17 / 25, rounded up
   localparam logic [12:0] LeapBias    = 13'd2029;
   localparam logic signed [14:0] EpochYear = 15'sd70;
   localparam logic signed [9:0]  DaysPerYear = 10'sd365;
   localparam logic signed [17:0] SecsPerDay  = 18'sd86400;

   typedef struct packed {
      logic signed [14:0] year;     // normalized years since 1900
      logic [3:0]         month;    // 0..11
      logic [4:0]         day;
      logic [16:0]        tod;      // seconds within the day
   } c2e_norm_type;

   typedef struct packed {
      logic signed [22:0] year_days; // 365 * (year - 70)
      logic signed [12:0] leaps;     // leap days between epoch and year start
      logic               leap;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [16:0]        tod;
   } c2e_year_type;

   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] d;
      unique case (month)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         4'd11:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

// ===== src/c2e_date_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_date_norm
// Stage 1: fold the month into the year and form seconds within the day.
// ----------------------------------------------------------------------------
module c2e_date_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [13:0]         years_since_1900,
   input  logic [7:0]          month_index,
   input  logic [4:0]          day_of_month,
   input  logic [4:0]          hour_of_day,
   input  logic [5:0]          minute_of_hour,
   input  logic [5:0]          second_of_minute,
   output logic                out_valid,
   output c2e_pkg::c2e_norm_type out_data
);
   import c2e_pkg::*;

   logic [9:0]   mon_biased;
   logic [8:0]   mon_pos;
   logic [16:0]  quot_prod;
   logic [5:0]   quot;
   logic [8:0]   mon_rem;
   logic         valid_ff;
   c2e_norm_type data_in;
   c2e_norm_type data_ff;

   // floor(month / 12) via reciprocal; exact for values below 512
   assign mon_biased = {{2{month_index[7]}}, month_index} + MonthBias;
   assign mon_pos    = mon_biased[8:0];
   assign quot_prod  = {8'b0, mon_pos} * Recip12;
   assign quot       = quot_prod[16:11];
   assign mon_rem    = mon_pos - ({3'b0, quot} * 9'd12);

   always_comb begin
      data_in.year  = {years_since_1900[13], years_since_1900}
                      + {9'b0, quot} - MonthCarry;
      data_in.month = mon_rem[3:0];
      data_in.day   = day_of_month;
      data_in.tod   = ({12'b0, hour_of_day} * 17'd3600)
                      + ({11'b0, minute_of_hour} * 17'd60)
                      + {11'b0, second_of_minute};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/c2e_year_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_year_days
// Stages 2 and 3: day count to 1 January of the year and the leap flag.
// ----------------------------------------------------------------------------
module c2e_year_days (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  c2e_pkg::c2e_norm_type in_data,
   output logic                  out_valid,
   output c2e_pkg::c2e_year_type out_data
);
   import c2e_pkg::*;

   // stage 2
   logic [14:0]        g_in;
   logic [24:0]        p100_in;
   logic [22:0]        p400_in;
   logic signed [14:0] year_off;
   logic signed [24:0] yd_full;
   logic               valid2_ff;
   logic [14:0]        g_ff;
   logic [24:0]        p100_ff;
   logic [22:0]        p400_ff;
   logic signed [22:0] yd_ff;
   c2e_norm_type       norm_ff;

   // stage 3
   logic [7:0]         q100;
   logic [5:0]         q400;
   logic [12:0]        q4;
   logic [14:0]        r100_full;
   logic [14:0]        r400_full;
   logic               leap;
   logic [12:0]        leaps;
   logic               valid3_ff;
   c2e_year_type       data_in;
   c2e_year_type       data_ff;

   assign g_in     = in_data.year + YearBias;
   // G/100 = (G/4)/25 and G/400 = (G/16)/25, reciprocal exact in range
   assign p100_in  = {12'b0, g_in[14:2]} * Recip25;
   assign p400_in  = 23'({14'b0, g_in[14:4]} * Recip25);
   assign year_off = in_data.year - EpochYear;
   assign yd_full  = year_off * DaysPerYear;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= in_valid;
      end
      g_ff    <= g_in;
      p100_ff <= p100_in;
      p400_ff <= p400_in;
      yd_ff   <= yd_full[22:0];
      norm_ff <= in_data;
   end

   assign q100      = p100_ff[24:17];
   assign q400      = p400_ff[22:17];
   assign q4        = g_ff[14:2];
   assign r100_full = g_ff - ({7'b0, q100} * 15'd100);
   assign r400_full = g_ff - ({9'b0, q400} * 15'd400);

   // year = G + 1 - 6400; G mod 4 == 3 means year divisible by 4
   assign leap  = (g_ff[1:0] == 2'b11)
                  && ((r100_full[6:0] != 7'd99) || (r400_full[8:0] == 9'd399));
   assign leaps = q4 - {5'b0, q100} + {7'b0, q400} - LeapBias;

   always_comb begin
      data_in.year_days = yd_ff;
      data_in.leaps     = leaps;
      data_in.leap      = leap;
      data_in.month     = norm_ff.month;
      data_in.day       = norm_ff.day;
      data_in.tod       = norm_ff.tod;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid3_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/c2e_sec_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_sec_accum
// Stages 4 to 6: day total, scale to seconds, add time of day.
// ----------------------------------------------------------------------------
module c2e_sec_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  c2e_pkg::c2e_year_type in_data,
   output logic                  out_valid,
   output logic [38:0]           epoch_seconds,
   output logic                  leap_year
);
   import c2e_pkg::*;

   logic [22:0]        days_in;
   logic               leap_day;
   logic               valid4_ff;
   logic signed [22:0] days_ff;
   logic [16:0]        tod4_ff;
   logic               leap4_ff;
   logic signed [40:0] prod_in;
   logic               valid5_ff;
   logic [39:0]        prod_ff;
   logic [16:0]        tod5_ff;
   logic               leap5_ff;
   logic [39:0]        secs_in;
   logic               valid6_ff;
   logic [38:0]        secs_ff;
   logic               leap6_ff;

   // add the leap day from March on
   assign leap_day = in_data.leap && (in_data.month >= 4'd2);
   assign days_in  = in_data.year_days
                     + {{10{in_data.leaps[12]}}, in_data.leaps}
                     + {14'b0, days_before(in_data.month)}
                     + {22'b0, leap_day}
                     + {18'b0, in_data.day}
                     - 23'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
      end else begin
         valid4_ff <= in_valid;
      end
      days_ff  <= days_in;
      tod4_ff  <= in_data.tod;
      leap4_ff <= in_data.leap;
   end

   assign prod_in = days_ff * SecsPerDay;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid5_ff <= 1'b0;
      end else begin
         valid5_ff <= valid4_ff;
      end
      prod_ff  <= prod_in[39:0];
      tod5_ff  <= tod4_ff;
      leap5_ff <= leap4_ff;
   end

   assign secs_in = prod_ff + {23'b0, tod5_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid6_ff <= 1'b0;
      end else begin
         valid6_ff <= valid5_ff;
      end
      secs_ff  <= secs_in[38:0];
      leap6_ff <= leap5_ff;
   end

   assign out_valid     = valid6_ff;
   assign epoch_seconds = secs_ff;
   assign leap_year     = leap6_ff;

endmodule

// ===== src/calendar_to_epoch_seconds.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds
// Gregorian date and time to signed seconds since 1970-01-01, with leap flag.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   --------  -----------------  --------------------------------------------
//   request   start && !busy     req_years_since_1900 .. req_second_of_minute
//   response  rsp_valid (strobe) rsp_epoch_seconds, rsp_leap_year
//
// Cycles: one item enters per clock while busy is low; each result strobes
//   once its item has passed the six register stages: month fold,
//   reciprocal products, leap count, day total, day-to-seconds multiply,
//   final add.
// Reset: synchronous; clears the valid bits of every stage and holds busy
//   high until the cycle after reset drops.
// Stalls: none on the result side; busy is raised only by reset.
//
// Datapath outline:
//   - fold month outside 0..11 into the year with floor division by 12
//   - count leap days as G/4 - G/100 + G/400 over a biased, positive year
//     G, so negative years need no special handling
//   - sum days, scale by 86400, add hour, minute and second seconds
//
module calendar_to_epoch_seconds (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [13:0] req_years_since_1900,
   input  logic [7:0]  req_month_index,
   input  logic [4:0]  req_day_of_month,
   input  logic [4:0]  req_hour_of_day,
   input  logic [5:0]  req_minute_of_hour,
   input  logic [5:0]  req_second_of_minute,
   output logic        rsp_valid,
   output logic [38:0] rsp_epoch_seconds,
   output logic        rsp_leap_year
);
   import c2e_pkg::*;

   logic         busy_ff;
   logic         accept;
   logic         norm_valid;
   c2e_norm_type norm_data;
   logic         year_valid;
   c2e_year_type year_data;

   // busy is a registered copy of reset, so it drops after reset is released
   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // stage 1: month fold and time of day
   c2e_date_norm u_date_norm (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .years_since_1900 (req_years_since_1900),
      .month_index      (req_month_index),
      .day_of_month     (req_day_of_month),
      .hour_of_day      (req_hour_of_day),
      .minute_of_hour   (req_minute_of_hour),
      .second_of_minute (req_second_of_minute),
      .out_valid        (norm_valid),
      .out_data         (norm_data)
   );

   // stages 2-3: days to the start of the year, leap flag
   c2e_year_days u_year_days (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_data   (norm_data),
      .out_valid (year_valid),
      .out_data  (year_data)
   );

   // stages 4-6: day total, seconds, registered result
   c2e_sec_accum u_sec_accum (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (year_valid),
      .in_data       (year_data),
      .out_valid     (rsp_valid),
      .epoch_seconds (rsp_epoch_seconds),
      .leap_year     (rsp_leap_year)
   );

endmodule

// ===== src/c2e_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2e_checker
// Port-level checks on latency and busy behavior of the converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c2e_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [13:0] req_years_since_1900,
   input logic [7:0]  req_month_index,
   input logic [4:0]  req_day_of_month,
   input logic [4:0]  req_hour_of_day,
   input logic [5:0]  req_minute_of_hour,
   input logic [5:0]  req_second_of_minute,
   input logic        rsp_valid,
   input logic [38:0] rsp_epoch_seconds,
   input logic        rsp_leap_year
);
   import c2e_pkg::*;

   logic accept;

   assign accept = start && !busy;

   // every item taken yields a strobe a fixed depth later
   `C2E_ASSERT_IMPL(a_item_to_rsp, clock, reset, accept, ##PipeDepth rsp_valid, "item lost in pipeline")

   // every strobe traces back to an item taken at that depth
   `C2E_ASSERT_IMPL(a_rsp_from_item, clock, reset, rsp_valid, $past(accept, PipeDepth), "result without item")

   // busy never rises outside reset
   `C2E_ASSERT_NEXT(a_busy_low, clock, reset, !reset, !busy, "busy raised outside reset")

endmodule

bind calendar_to_epoch_seconds c2e_checker u_c2e_checker (.*);
